### sv/bgc_pkg.sv
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Shared types and constants for the gesture classifier core.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int TIMER_WIDTH_DEF = 16;

  localparam int CFG_WIDTH   = 16;
  localparam int DEB_WIDTH   = 8;
  localparam int GEST_WIDTH  = 2;
  localparam int IDX_WIDTH   = 2;
  localparam int TDATA_WIDTH = 8;

  // Register indexes of the configuration port.
  localparam logic [IDX_WIDTH-1:0] REG_HOLD     = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_WINDOW   = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE = 2'd2;
  localparam logic [IDX_WIDTH-1:0] REG_LOCKOUT  = 2'd3;

  localparam logic [CFG_WIDTH-1:0] HOLD_RESET     = 16'd300;
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET   = 16'd150;
  localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RESET = 8'd5;
  localparam logic [CFG_WIDTH-1:0] LOCKOUT_RESET  = 16'd500;

  // Gesture codes.
  localparam logic [GEST_WIDTH-1:0] G_SINGLE = 2'd0;
  localparam logic [GEST_WIDTH-1:0] G_DOUBLE = 2'd1;
  localparam logic [GEST_WIDTH-1:0] G_HOLD   = 2'd2;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] hold_ticks;
    logic [CFG_WIDTH-1:0] double_window_ticks;
    logic [DEB_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [GEST_WIDTH-1:0] gesture;
  } result_t;

endpackage

### sv/bgc_fsm.sv
// ----------------------------------------------------------------------------
// Gesture state machine
// Debounce, hold, double-tap window and lockout tracking, one sample a step.
// ----------------------------------------------------------------------------
module bgc_fsm #(
  parameter int TIMER_WIDTH = bgc_pkg::TIMER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bgc_pkg::cfg_t     cfg,
  input  logic              step,
  input  logic              level,
  output bgc_pkg::result_t  result
);

  localparam logic [2:0] M_IDLE         = 3'd0;
  localparam logic [2:0] M_PRESSED      = 3'd1;
  localparam logic [2:0] M_WINDOW       = 3'd2;
  localparam logic [2:0] M_LOCK_HOLD    = 3'd3;
  localparam logic [2:0] M_LOCK_DOUBLE  = 3'd4;
  localparam logic [2:0] M_WAIT_RELEASE = 3'd5;

  localparam int CW = (TIMER_WIDTH > bgc_pkg::CFG_WIDTH) ? TIMER_WIDTH : bgc_pkg::CFG_WIDTH;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
  localparam logic [bgc_pkg::DEB_WIDTH-1:0] COUNT_MAX = {bgc_pkg::DEB_WIDTH{1'b1}};

  logic [2:0]                      mode;
  logic [2:0]                      mode_next;
  logic [TIMER_WIDTH-1:0]          elapsed;
  logic [TIMER_WIDTH-1:0]          elapsed_next;
  logic [bgc_pkg::DEB_WIDTH-1:0]   stable_count;
  logic [bgc_pkg::DEB_WIDTH-1:0]   stable_count_next;

  logic [TIMER_WIDTH-1:0]          elapsed_tick;
  logic [CW-1:0]                   elapsed_wide;
  logic [CW-1:0]                   hold_wide;
  logic [CW-1:0]                   window_wide;
  logic [CW-1:0]                   lockout_wide;
  logic [bgc_pkg::DEB_WIDTH-1:0]   count_inc;
  logic                            press_ok;

  // The timer saturates so that a limit beyond its range is never reached.
  assign elapsed_tick = (elapsed == TIMER_MAX) ? elapsed : elapsed + 1'b1;
  assign elapsed_wide = CW'(elapsed_tick);
  assign hold_wide    = CW'(cfg.hold_ticks);
  assign window_wide  = CW'(cfg.double_window_ticks);
  assign lockout_wide = CW'(cfg.lockout_ticks);

  assign count_inc = (stable_count == COUNT_MAX) ? stable_count : stable_count + 1'b1;
  assign press_ok  = level && (count_inc >= cfg.debounce_ticks);

  always_comb begin
    mode_next         = mode;
    elapsed_next      = elapsed;
    stable_count_next = stable_count;
    result.valid      = 1'b0;
    result.gesture    = bgc_pkg::G_SINGLE;
    unique case (mode)
      M_PRESSED: begin
        if (!level) begin
          mode_next         = M_WINDOW;
          elapsed_next      = '0;
          stable_count_next = '0;
        end else if (elapsed_wide > hold_wide) begin
          mode_next         = M_LOCK_HOLD;
          elapsed_next      = '0;
          stable_count_next = '0;
          result.valid      = 1'b1;
          result.gesture    = bgc_pkg::G_HOLD;
        end else begin
          elapsed_next = elapsed_tick;
        end
      end
      M_WINDOW: begin
        if (press_ok) begin
          mode_next         = M_LOCK_DOUBLE;
          elapsed_next      = '0;
          stable_count_next = '0;
          result.valid      = 1'b1;
          result.gesture    = bgc_pkg::G_DOUBLE;
        end else if (elapsed_wide >= window_wide) begin
          mode_next         = M_IDLE;
          elapsed_next      = '0;
          stable_count_next = '0;
          result.valid      = 1'b1;
          result.gesture    = bgc_pkg::G_SINGLE;
        end else begin
          elapsed_next      = elapsed_tick;
          stable_count_next = level ? count_inc : '0;
        end
      end
      M_LOCK_HOLD, M_LOCK_DOUBLE: begin
        if (elapsed_wide >= lockout_wide) begin
          mode_next         = (mode == M_LOCK_HOLD) ? M_WAIT_RELEASE : M_IDLE;
          elapsed_next      = '0;
          stable_count_next = '0;
        end else begin
          elapsed_next = elapsed_tick;
        end
      end
      M_WAIT_RELEASE: begin
        if (!level) begin
          mode_next         = M_IDLE;
          elapsed_next      = '0;
          stable_count_next = '0;
        end
      end
      default: begin
        // Idle and the unused codes behave the same.
        mode_next = M_IDLE;
        if (press_ok) begin
          mode_next         = M_PRESSED;
          elapsed_next      = '0;
          stable_count_next = '0;
        end else begin
          stable_count_next = level ? count_inc : '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      elapsed      <= '0;
      stable_count <= '0;
    end else if (step) begin
      mode         <= mode_next;
      elapsed      <= elapsed_next;
      stable_count <= stable_count_next;
    end
  end

endmodule

### sv/bgc_out_fifo.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry buffer that decouples the state machine from the output stall.
// ----------------------------------------------------------------------------
module bgc_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [bgc_pkg::GEST_WIDTH-1:0] push_data,
  output logic                           has_room,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bgc_pkg::GEST_WIDTH-1:0] out_data
);

  logic [bgc_pkg::GEST_WIDTH-1:0] mem [2];
  logic                           wr_ptr;
  logic                           rd_ptr;
  logic [1:0]                     count;
  logic                           pop;

  assign has_room  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/button_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// Button gesture classifier core
// Classifies a sampled push-button level into single, double and hold taps.
// ----------------------------------------------------------------------------
// Path: a sample accepted into the input register drives the state update,
// which writes any gesture into the result buffer that drives m_tvalid.
// Throughput: one sample per cycle while the result buffer has a free entry;
// the two-entry result buffer absorbs output stalls.
// Reset: synchronous rst clears state to idle and restores register defaults.
module button_gesture_classifier_core #(
  parameter int TIMER_WIDTH = bgc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bgc_pkg::TDATA_WIDTH-1:0] s_tdata,  // [0] button_level
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bgc_pkg::TDATA_WIDTH-1:0] m_tdata,  // [1:0] gesture
  input  logic                            cfg_we,
  input  logic [bgc_pkg::IDX_WIDTH-1:0]   cfg_index,
  input  logic [bgc_pkg::CFG_WIDTH-1:0]   cfg_data
);

  bgc_pkg::cfg_t                  cfg;
  bgc_pkg::result_t               result;
  logic                           in_valid;
  logic                           in_level;
  logic                           has_room;
  logic                           step;
  logic [bgc_pkg::GEST_WIDTH-1:0] out_gesture;

  // The held sample moves on whenever the buffer has a free entry.
  assign step     = in_valid && has_room;
  assign s_tready = !in_valid || has_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks          <= bgc_pkg::HOLD_RESET;
      cfg.double_window_ticks <= bgc_pkg::WINDOW_RESET;
      cfg.debounce_ticks      <= bgc_pkg::DEBOUNCE_RESET;
      cfg.lockout_ticks       <= bgc_pkg::LOCKOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgc_pkg::REG_HOLD:     cfg.hold_ticks          <= cfg_data;
        bgc_pkg::REG_WINDOW:   cfg.double_window_ticks <= cfg_data;
        bgc_pkg::REG_DEBOUNCE: cfg.debounce_ticks      <= cfg_data[bgc_pkg::DEB_WIDTH-1:0];
        bgc_pkg::REG_LOCKOUT:  cfg.lockout_ticks       <= cfg_data;
        default:               cfg.hold_ticks          <= cfg.hold_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_level <= s_tdata[0];
    end
  end

  bgc_fsm #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_fsm (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .level  (in_level),
    .result (result)
  );

  bgc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (step && result.valid),
    .push_data (result.gesture),
    .has_room  (has_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_gesture)
  );

  assign m_tdata = {{(bgc_pkg::TDATA_WIDTH - bgc_pkg::GEST_WIDTH){1'b0}}, out_gesture};

endmodule
